/* rtl/vbsg_pkg.sv */
// ----------------------------------------------------------------------------
// vbsg_pkg
// Shared types and constants for the voxel brush scan generator.
// ----------------------------------------------------------------------------
package vbsg_pkg;

    localparam int CoordW = 16;
    localparam int SizeW  = 8;
    localparam int OffW   = 8;
    localparam int SqW    = 16;
    localparam int SumW   = 18;
    localparam int CountW = 19;

    // input word kinds
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    // brush shapes
    localparam logic [1:0] SHAPE_CUBE   = 2'd0;
    localparam logic [1:0] SHAPE_SPHERE = 2'd1;

    // result status codes
    typedef enum logic [1:0] {
        ST_POSITION = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2,
        ST_FINISHED = 2'd3
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic reject;
        logic idle_next;
        logic emit;
        logic init;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic begin_ok;
        logic active;
        logic in_shape;
        logic wrap_all;
        logic res_busy;
    } dp_stat_t;

endpackage

/* rtl/vbsg_in_if.sv */
// ----------------------------------------------------------------------------
// vbsg_in_if
// Request channel: begin or next words with brush anchor, shape and size.
// ----------------------------------------------------------------------------
interface vbsg_in_if;

    logic              valid;
    logic              ready;
    logic              kind;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic signed [15:0] anchor_z;
    logic [1:0]        brush_shape;
    logic [7:0]        brush_size;

    modport source (
        output valid, kind, anchor_x, anchor_y, anchor_z, brush_shape, brush_size,
        input  ready
    );

    modport sink (
        input  valid, kind, anchor_x, anchor_y, anchor_z, brush_shape, brush_size,
        output ready
    );

endinterface

/* rtl/vbsg_out_if.sv */
// ----------------------------------------------------------------------------
// vbsg_out_if
// Response channel: status, voxel position, ordinal and last flag.
// ----------------------------------------------------------------------------
interface vbsg_out_if;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic signed [15:0] voxel_x;
    logic signed [15:0] voxel_y;
    logic signed [15:0] voxel_z;
    logic [18:0]       ordinal;
    logic              last;

    modport source (
        output valid, status, voxel_x, voxel_y, voxel_z, ordinal, last,
        input  ready
    );

    modport sink (
        input  valid, status, voxel_x, voxel_y, voxel_z, ordinal, last,
        output ready
    );

endinterface

/* rtl/vbsg_ctrl.sv */
// ----------------------------------------------------------------------------
// vbsg_ctrl
// Controller: accepts request words and sequences load, init and the
// one-position-per-cycle settle walk of the datapath.
// ----------------------------------------------------------------------------
module vbsg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_kind,
    input  vbsg_pkg::dp_stat_t   stat,
    output logic                 in_ready,
    output vbsg_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_SETTLE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // ready only when idle and the result slot is free
    assign in_ready = (state_reg == S_IDLE) && !stat.res_busy;
    assign accept   = in_valid && in_ready;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == vbsg_pkg::KIND_BEGIN)
                    begin
                        if (stat.begin_ok)
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_INIT;
                        end
                        else
                        begin
                            cmd.reject = 1'b1;
                            cmd.finish = 1'b1;
                        end
                    end
                    else if (stat.active)
                    begin
                        cmd.emit = 1'b1;
                        cmd.step = 1'b1;
                        if (stat.wrap_all)
                        begin
                            cmd.finish = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SETTLE;
                        end
                    end
                    else
                    begin
                        cmd.idle_next = 1'b1;
                        cmd.finish    = 1'b1;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_SETTLE;
            end
            S_SETTLE:
            begin
                if (stat.in_shape)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.wrap_all)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/vbsg_datapath.sv */
// ----------------------------------------------------------------------------
// vbsg_datapath
// Datapath: brush registers, scan offsets with incremental squared
// distances, result slot and output register.
// ----------------------------------------------------------------------------
module vbsg_datapath #(
    parameter int MAX_SIZE = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vbsg_pkg::ctrl_cmd_t         cmd,
    output vbsg_pkg::dp_stat_t          stat,
    input  logic signed [vbsg_pkg::CoordW-1:0] anchor_x,
    input  logic signed [vbsg_pkg::CoordW-1:0] anchor_y,
    input  logic signed [vbsg_pkg::CoordW-1:0] anchor_z,
    input  logic [1:0]                  brush_shape,
    input  logic [vbsg_pkg::SizeW-1:0]  brush_size,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [1:0]                  status,
    output logic signed [vbsg_pkg::CoordW-1:0] voxel_x,
    output logic signed [vbsg_pkg::CoordW-1:0] voxel_y,
    output logic signed [vbsg_pkg::CoordW-1:0] voxel_z,
    output logic [vbsg_pkg::CountW-1:0] ordinal,
    output logic                        last
);

    localparam int CoordW = vbsg_pkg::CoordW;
    localparam int SizeW  = vbsg_pkg::SizeW;
    localparam int OffW   = vbsg_pkg::OffW;
    localparam int SqW    = vbsg_pkg::SqW;
    localparam int SumW   = vbsg_pkg::SumW;
    localparam int CountW = vbsg_pkg::CountW;

    // brush and scan state
    logic signed [CoordW-1:0] base_x_reg, base_y_reg, base_z_reg;
    logic                     sphere_reg;
    logic [SizeW-1:0]         edge_reg;
    logic signed [OffW-1:0]   off_x_reg, off_y_reg, off_z_reg;
    logic                     active_reg;
    logic [CountW-1:0]        count_reg;
    logic [SqW-1:0]           size_sq_reg;
    logic [SqW-1:0]           lo_sq_reg;
    logic [SqW-1:0]           sq_x_reg, sq_y_reg, sq_z_reg;

    // result slot and output register
    logic                     res_valid_reg;
    vbsg_pkg::status_t        res_status_reg;
    logic signed [CoordW-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic [CountW-1:0]        res_ord_reg;
    logic                     res_last_reg;
    logic                     out_valid_reg;
    vbsg_pkg::status_t        out_status_reg;
    logic signed [CoordW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic [CountW-1:0]        out_ord_reg;
    logic                     out_last_reg;

    logic [SizeW-1:0]         edge_m1;
    logic [SizeW-1:0]         size_m1;
    logic signed [OffW-1:0]   hi_off;
    logic signed [OffW-1:0]   lo_off;
    logic signed [OffW-1:0]   lo_new;
    logic                     even;
    logic                     wrap_x, wrap_y, wrap_z, wrap_all;
    logic [SumW-1:0]          dist_sum;
    logic                     in_shape;
    logic [SqW:0]             lo_sq_wide;
    logic [SqW-1:0]           lo_sq_calc;
    logic [SqW-1:0]           size_ext;
    logic [SqW-1:0]           size_sq_calc;
    logic [CountW-1:0]        count_inc;
    logic                     transfer;

    // squared doubled distance after one step up: d^2 + 8*off - 4*even + 4
    function automatic logic [SqW-1:0] sq_step(
        input logic [SqW-1:0]         sq,
        input logic signed [OffW-1:0] off,
        input logic                   ev
    );
        logic [SumW-1:0] off_ext;
        logic [SumW-1:0] acc;
        off_ext = {{(SumW-OffW){off[OffW-1]}}, off};
        acc     = {{(SumW-SqW){1'b0}}, sq} + (off_ext << 3) + SumW'(4)
                  - SumW'({ev, 2'b00});
        return acc[SqW-1:0];
    endfunction

    // anchor plus offset, clamped to the signed coordinate range
    function automatic logic signed [CoordW-1:0] sat_add(
        input logic signed [CoordW-1:0] b,
        input logic signed [OffW-1:0]   o
    );
        logic [CoordW:0] s;
        s = {b[CoordW-1], b} + {{(CoordW+1-OffW){o[OffW-1]}}, o};
        if (s[CoordW] != s[CoordW-1])
        begin
            return s[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
        end
        return s[CoordW-1:0];
    endfunction

    // offset range of the loaded brush and of the incoming brush
    assign edge_m1 = edge_reg - 1'b1;
    assign size_m1 = brush_size - 1'b1;
    assign hi_off  = $signed({1'b0, edge_reg[SizeW-1:1]});
    assign lo_off  = -$signed({1'b0, edge_m1[SizeW-1:1]});
    assign lo_new  = -$signed({1'b0, size_m1[SizeW-1:1]});
    assign even    = ~edge_reg[0];

    // scan wrap detection
    assign wrap_x   = (off_x_reg == hi_off);
    assign wrap_y   = (off_y_reg == hi_off);
    assign wrap_z   = (off_z_reg == hi_off);
    assign wrap_all = wrap_x && wrap_y && wrap_z;

    // sphere membership from the running squared distances
    assign dist_sum = {{(SumW-SqW){1'b0}}, sq_x_reg} + {{(SumW-SqW){1'b0}}, sq_y_reg}
                    + {{(SumW-SqW){1'b0}}, sq_z_reg};
    assign in_shape = !sphere_reg || (dist_sum <= {{(SumW-SqW){1'b0}}, size_sq_reg});

    // squared distance at the low corner: (size - 1)^2
    assign lo_sq_wide = {1'b0, size_sq_reg} - {{(SqW-SizeW){1'b0}}, edge_reg, 1'b0}
                      + (SqW+1)'(1);
    assign lo_sq_calc = lo_sq_wide[SqW-1:0];
    assign size_ext     = SqW'(brush_size);
    assign size_sq_calc = size_ext * size_ext;
    assign count_inc    = count_reg + 1'b1;

    // status to controller
    assign stat.begin_ok = (brush_size != '0) && (brush_size <= SizeW'(MAX_SIZE))
                         && (brush_shape[1] == 1'b0);
    assign stat.active   = active_reg;
    assign stat.in_shape = in_shape;
    assign stat.wrap_all = wrap_all;
    assign stat.res_busy = res_valid_reg;

    // brush and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg  <= '0;
            base_y_reg  <= '0;
            base_z_reg  <= '0;
            sphere_reg  <= 1'b0;
            edge_reg    <= '0;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            off_z_reg   <= '0;
            active_reg  <= 1'b0;
            count_reg   <= '0;
            size_sq_reg <= '0;
            lo_sq_reg   <= '0;
            sq_x_reg    <= '0;
            sq_y_reg    <= '0;
            sq_z_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                base_x_reg  <= anchor_x;
                base_y_reg  <= anchor_y;
                base_z_reg  <= anchor_z;
                sphere_reg  <= (brush_shape == vbsg_pkg::SHAPE_SPHERE);
                edge_reg    <= brush_size;
                off_x_reg   <= lo_new;
                off_y_reg   <= lo_new;
                off_z_reg   <= lo_new;
                active_reg  <= 1'b1;
                count_reg   <= '0;
                size_sq_reg <= size_sq_calc;
            end
            if (cmd.reject)
            begin
                active_reg <= 1'b0;
                count_reg  <= '0;
            end
            if (cmd.init)
            begin
                lo_sq_reg <= lo_sq_calc;
                sq_x_reg  <= lo_sq_calc;
                sq_y_reg  <= lo_sq_calc;
                sq_z_reg  <= lo_sq_calc;
            end
            if (cmd.emit)
            begin
                count_reg <= count_inc;
            end
            // one step in z, y, x order
            if (cmd.step)
            begin
                if (!wrap_x)
                begin
                    off_x_reg <= off_x_reg + 1'b1;
                    sq_x_reg  <= sq_step(sq_x_reg, off_x_reg, even);
                end
                else
                begin
                    off_x_reg <= lo_off;
                    sq_x_reg  <= lo_sq_reg;
                    if (!wrap_y)
                    begin
                        off_y_reg <= off_y_reg + 1'b1;
                        sq_y_reg  <= sq_step(sq_y_reg, off_y_reg, even);
                    end
                    else
                    begin
                        off_y_reg <= lo_off;
                        sq_y_reg  <= lo_sq_reg;
                        if (!wrap_z)
                        begin
                            off_z_reg <= off_z_reg + 1'b1;
                            sq_z_reg  <= sq_step(sq_z_reg, off_z_reg, even);
                        end
                        else
                        begin
                            off_z_reg  <= lo_off;
                            sq_z_reg   <= lo_sq_reg;
                            active_reg <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    assign transfer = res_valid_reg && (!out_valid_reg || out_ready);

    // result slot and output word handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (transfer)
            begin
                out_valid_reg <= 1'b1;
                res_valid_reg <= 1'b0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.finish)
            begin
                res_valid_reg <= 1'b1;
            end
        end
    end

    // result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load || cmd.reject || cmd.idle_next)
        begin
            res_x_reg    <= '0;
            res_y_reg    <= '0;
            res_z_reg    <= '0;
            res_last_reg <= 1'b0;
            res_ord_reg  <= cmd.idle_next ? count_reg : '0;
            if (cmd.load)
            begin
                res_status_reg <= vbsg_pkg::ST_ACCEPTED;
            end
            else if (cmd.reject)
            begin
                res_status_reg <= vbsg_pkg::ST_REJECTED;
            end
            else
            begin
                res_status_reg <= vbsg_pkg::ST_FINISHED;
            end
        end
        // scan ran out during the settle walk
        if (cmd.step && wrap_all)
        begin
            res_last_reg <= (res_status_reg == vbsg_pkg::ST_POSITION);
        end
        if (cmd.emit)
        begin
            res_status_reg <= vbsg_pkg::ST_POSITION;
            res_x_reg      <= sat_add(base_x_reg, off_x_reg);
            res_y_reg      <= sat_add(base_y_reg, off_y_reg);
            res_z_reg      <= sat_add(base_z_reg, off_z_reg);
            res_ord_reg    <= count_inc;
            res_last_reg   <= wrap_all;
        end
        if (transfer)
        begin
            out_status_reg <= res_status_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_z_reg      <= res_z_reg;
            out_ord_reg    <= res_ord_reg;
            out_last_reg   <= res_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign voxel_x   = out_x_reg;
    assign voxel_y   = out_y_reg;
    assign voxel_z   = out_z_reg;
    assign ordinal   = out_ord_reg;
    assign last      = out_last_reg;

endmodule

/* rtl/voxel_brush_scan_generator_core.sv */
// Sequence: a next word in cube mode reaches the result slot through the emit step and the settle
// check; in sphere mode the settle walk also steps over each skipped outside position; a begin
// word passes load, init and the settle walk. Reject, scan-finished and final-position answers
// go straight to the result slot; the output register follows. One word at a time: a new word is
// taken the cycle after the answer moves to the output register.
// Reset: asynchronous active low, clears brush state and goes idle; no clearing pass.
// ----------------------------------------------------------------------------
// voxel_brush_scan_generator_core
// Cube and sphere brush rasterizer that returns one voxel position per next
// word in z, y, x scan order.
// ----------------------------------------------------------------------------
module voxel_brush_scan_generator_core #(
    parameter int MAX_SIZE = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    vbsg_in_if.sink      req,
    vbsg_out_if.source   rsp
);

    vbsg_pkg::ctrl_cmd_t cmd;
    vbsg_pkg::dp_stat_t  stat;

    // sequencing
    vbsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_kind  (req.kind),
        .stat     (stat),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    // brush registers, scan walk and result words
    vbsg_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .anchor_x    (req.anchor_x),
        .anchor_y    (req.anchor_y),
        .anchor_z    (req.anchor_z),
        .brush_shape (req.brush_shape),
        .brush_size  (req.brush_size),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .status      (rsp.status),
        .voxel_x     (rsp.voxel_x),
        .voxel_y     (rsp.voxel_y),
        .voxel_z     (rsp.voxel_z),
        .ordinal     (rsp.ordinal),
        .last        (rsp.last)
    );

endmodule

/* rtl/vbsg_checker.sv */
// ----------------------------------------------------------------------------
// vbsg_checker
// Port-level checks for the brush scan generator, bound to the top level.
// ----------------------------------------------------------------------------
module vbsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] voxel_x,
    input logic [15:0] voxel_y,
    input logic [15:0] voxel_z,
    input logic [18:0] ordinal,
    input logic        last
);

    // one word in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous word still in flight");

    // only position words carry coordinates or the last flag
    a_non_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != vbsg_pkg::ST_POSITION)
        |-> (voxel_x == '0) && (voxel_y == '0) && (voxel_z == '0) && !last)
        else $error("non-position word carries coordinates or last");

    // accept and reject answers report a zero ordinal
    a_begin_ordinal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == vbsg_pkg::ST_ACCEPTED || status == vbsg_pkg::ST_REJECTED)
        |-> (ordinal == '0))
        else $error("begin answer with nonzero ordinal");

    // stalled response word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(status) && $stable(ordinal) && $stable(voxel_x))
        else $error("stalled response word changed");

endmodule

bind voxel_brush_scan_generator_core vbsg_checker u_vbsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .voxel_x   (rsp.voxel_x),
    .voxel_y   (rsp.voxel_y),
    .voxel_z   (rsp.voxel_z),
    .ordinal   (rsp.ordinal),
    .last      (rsp.last)
);
